// File: design/dav_pkg.sv
// shared types and constants for the dds oscillator with adsr envelope voice
package dav_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_PHASE_BITS  = 16;

  localparam int MODE_W     = 2;
  localparam int TUNE_W     = 16;
  localparam int SAMPLE_W   = 8;
  localparam int TIDX_W     = 8;
  localparam int PWM_W      = 8;
  localparam int VOL_W      = 5;
  localparam int CNT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int AR_W = 8;
  localparam int DR_W = 8;
  localparam int ST_W = 16;
  localparam int RR_W = 10;

  localparam int VOL_SHIFT = 5;
  localparam int PWM_MID   = 128;
  localparam int PROD_W    = SAMPLE_W + VOL_W + 1;

  localparam logic [VOL_W-1:0] FULL_VOL    = 5'd31;
  localparam logic [CNT_W-1:0] COUNTER_MAX = {CNT_W{1'b1}};

  localparam logic [AR_W-1:0]  ATTACK_RST       = 8'd7;
  localparam logic [DR_W-1:0]  DECAY_RST        = 8'd50;
  localparam logic [VOL_W-1:0] SUSTAIN_LVL_RST  = 5'd20;
  localparam logic [ST_W-1:0]  SUSTAIN_TIME_RST = 16'd2000;
  localparam logic [RR_W-1:0]  RELEASE_RST      = 10'd200;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_NOTE  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK   = 3'd0,
    REG_DECAY    = 3'd1,
    REG_SUS_LVL  = 3'd2,
    REG_SUS_TIME = 3'd3,
    REG_RELEASE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [VOL_W-1:0] vol_pre;
    logic [VOL_W-1:0] vol_post;
    logic             active;
  } tick_info_t;

endpackage

// File: design/dds_adsr_voice_core.sv
// one-voice dds oscillator with wave ram and adsr envelope
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | mode, tuning word, table index, table value
//   out_    | output    | out_valid/out_stall | pwm level, envelope volume, note active
//   cfg_    | input     | cfg_we              | register index, data
//
// one transaction per cycle while in_stall is low; a taken tick has its wave ram read
// registered in the ram read register, then its volume multiply in the output register
// after reset and after every cfg write in_stall stays high while the envelope
// thresholds are rebuilt from the registers
// out_stall holds the output register and the ram read register, in_stall follows
// when both are full
module dds_adsr_voice_core #(
  parameter int TABLE_DEPTH = dav_pkg::DEF_TABLE_DEPTH,
  parameter int PHASE_BITS  = dav_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dav_pkg::MODE_W-1:0]        in_mode,
  input  logic [dav_pkg::TUNE_W-1:0]        in_tuning_word,
  input  logic [dav_pkg::TIDX_W-1:0]        in_table_index,
  input  logic signed [dav_pkg::SAMPLE_W-1:0] in_table_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dav_pkg::PWM_W-1:0]         out_pwm_level,
  output logic [dav_pkg::VOL_W-1:0]         out_envelope_volume,
  output logic                              out_note_active,
  input  logic                              cfg_we,
  input  logic [dav_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dav_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dav_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int A_W   = AR_W + VOL_W;
  localparam int SP_W  = DR_W + VOL_W;
  localparam int D_W   = A_W + 1;
  localparam int R_W   = ST_W + 1;
  localparam int REL_W = RR_W + VOL_W + 1;
  localparam logic signed [PROD_W-1:0] PWM_BIAS = PROD_W'(PWM_MID << VOL_SHIFT);

  function automatic logic [AW-1:0] mod_depth(input logic [TIDX_W-1:0] v);
    logic [16:0] x;
    x = {9'd0, v};
    for (int k = 3; k >= 0; k--) begin
      if (x >= 17'(TABLE_DEPTH << k)) x = x - 17'(TABLE_DEPTH << k);
    end
    return x[AW-1:0];
  endfunction

  logic [AR_W-1:0]  attack_r;
  logic [DR_W-1:0]  decay_r;
  logic [VOL_W-1:0] sus_lvl_r;
  logic [ST_W-1:0]  sus_time_r;
  logic [RR_W-1:0]  release_r;
  logic [1:0]       settle_r;

  logic [A_W-1:0]  a_end_r;
  logic [SP_W-1:0] d_span_r;
  logic [D_W-1:0]  d_end_r;
  logic [R_W-1:0]  r_start_r;

  logic [A_W-1:0]          att_thr_r;
  logic [SP_W-1:0]         dec_thr_r;
  logic signed [REL_W-1:0] rel_thr_r;

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [VOL_W-1:0]      vol_r;
  logic [CNT_W-1:0]      cnt_r;

  logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic                       s1_valid_r;
  tick_info_t                 s1_info_r;

  logic             out_valid_r;
  logic [PWM_W-1:0] out_pwm_r;
  logic [VOL_W-1:0] out_vol_r;
  logic             out_act_r;

  logic out_adv, s1_free, in_fire, tick_fire, note_fire, wr_fire;
  mode_t mode;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [CNT_W-1:0]      cnt_inc, cnt_nxt, elapsed;
  logic                  vol_up, vol_dn;
  logic [VOL_W-1:0]      vol_nxt;
  logic signed [PROD_W-1:0] prod, pwm_sum;

  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_free   = !s1_valid_r || out_adv;
  assign in_stall  = (settle_r != 2'd0) || !s1_free;
  assign in_fire   = in_valid && !in_stall;
  assign mode      = mode_t'(in_mode);
  assign tick_fire = in_fire && (mode == MODE_TICK);
  assign note_fire = in_fire && (mode == MODE_NOTE);
  assign wr_fire   = in_fire && (mode == MODE_WRITE);

  assign phase_nxt = phase_r + step_r;
  assign rd_addr   = mod_depth(phase_nxt[PHASE_BITS-1 -: TIDX_W]);
  assign wr_addr   = mod_depth(in_table_index);

  // envelope step
  always_comb begin
    cnt_inc = (cnt_r != COUNTER_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
    cnt_nxt = cnt_r;
    elapsed = cnt_inc - CNT_W'(r_start_r);
    vol_up  = 1'b0;
    vol_dn  = 1'b0;
    if (cnt_r != '0) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc < CNT_W'(a_end_r)) begin
        if ((cnt_inc > CNT_W'(att_thr_r)) && (vol_r < FULL_VOL)) vol_up = 1'b1;
      end else if (cnt_inc < CNT_W'(d_end_r)) begin
        if (((cnt_inc - CNT_W'(a_end_r)) > CNT_W'(dec_thr_r)) && (vol_r > sus_lvl_r)) begin
          vol_dn = 1'b1;
        end
      end else if (cnt_inc > CNT_W'(r_start_r)) begin
        if (rel_thr_r[REL_W-1] || (elapsed > CNT_W'($unsigned(rel_thr_r)))) begin
          if (vol_r != '0) vol_dn = 1'b1;
          else cnt_nxt = '0;
        end
      end
    end
    vol_nxt = vol_r;
    if (vol_up) vol_nxt = vol_r + VOL_W'(1);
    else if (vol_dn) vol_nxt = vol_r - VOL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r   <= ATTACK_RST;
      decay_r    <= DECAY_RST;
      sus_lvl_r  <= SUSTAIN_LVL_RST;
      sus_time_r <= SUSTAIN_TIME_RST;
      release_r  <= RELEASE_RST;
      settle_r   <= 2'd2;
    end else begin
      if (cfg_we) begin
        settle_r <= 2'd2;
        unique case (cfg_reg_t'(cfg_index))
          REG_ATTACK:   attack_r   <= cfg_data[AR_W-1:0];
          REG_DECAY:    decay_r    <= cfg_data[DR_W-1:0];
          REG_SUS_LVL:  sus_lvl_r  <= cfg_data[VOL_W-1:0];
          REG_SUS_TIME: sus_time_r <= cfg_data[ST_W-1:0];
          REG_RELEASE:  release_r  <= cfg_data[RR_W-1:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // derived envelope times, registered from the config registers; d_end_r and r_start_r build on a_end_r and d_span_r
  always_ff @(posedge clk) begin
    a_end_r   <= {{VOL_W{1'b0}}, attack_r} * {{AR_W{1'b0}}, FULL_VOL};
    d_span_r  <= {{DR_W{1'b0}}, 5'(FULL_VOL - sus_lvl_r)} * {{VOL_W{1'b0}}, decay_r};
    d_end_r   <= D_W'(a_end_r) + D_W'(d_span_r);
    r_start_r <= R_W'(a_end_r) + R_W'(d_span_r) + R_W'(sus_time_r);
  end

  // volume dependent thresholds, rebuilt while settling and tracked per volume step
  always_ff @(posedge clk) begin
    if (settle_r == 2'd2) begin
      att_thr_r <= {{VOL_W{1'b0}}, attack_r} * {{AR_W{1'b0}}, vol_r};
      dec_thr_r <= {{DR_W{1'b0}}, 5'(FULL_VOL - vol_r)} * {{VOL_W{1'b0}}, decay_r};
      rel_thr_r <= ($signed(REL_W'(sus_lvl_r)) - $signed(REL_W'(vol_r)))
                   * $signed(REL_W'(release_r));
    end else if (tick_fire) begin
      if (vol_up) begin
        att_thr_r <= att_thr_r + A_W'(attack_r);
        dec_thr_r <= dec_thr_r - SP_W'(decay_r);
        rel_thr_r <= rel_thr_r - $signed(REL_W'(release_r));
      end else if (vol_dn) begin
        att_thr_r <= att_thr_r - A_W'(attack_r);
        dec_thr_r <= dec_thr_r + SP_W'(decay_r);
        rel_thr_r <= rel_thr_r + $signed(REL_W'(release_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      vol_r   <= '0;
      cnt_r   <= '0;
    end else if (tick_fire) begin
      phase_r <= phase_nxt;
      vol_r   <= vol_nxt;
      cnt_r   <= cnt_nxt;
    end else if (note_fire && (cnt_r == '0)) begin
      step_r <= PHASE_BITS'(in_tuning_word);
      cnt_r  <= CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) wave_mem[wr_addr] <= in_table_value;
    if (tick_fire) begin
      rdata_r            <= wave_mem[rd_addr];
      s1_info_r.vol_pre  <= vol_r;
      s1_info_r.vol_post <= vol_nxt;
      s1_info_r.active   <= (cnt_nxt != '0);
    end
  end

  assign prod    = rdata_r * $signed({1'b0, s1_info_r.vol_pre});
  assign pwm_sum = prod + PWM_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= tick_fire;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_pwm_r <= pwm_sum[VOL_SHIFT +: PWM_W];
      out_vol_r <= s1_info_r.vol_post;
      out_act_r <= s1_info_r.active;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pwm_level       = out_pwm_r;
  assign out_envelope_volume = out_vol_r;
  assign out_note_active     = out_act_r;

endmodule

// File: design/dav_checker.sv
// port level checks for the voice core, bound into every dds_adsr_voice_core instance
module dav_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [dav_pkg::PWM_W-1:0]           out_pwm_level,
  input logic [dav_pkg::VOL_W-1:0]           out_envelope_volume,
  input logic                                out_note_active,
  input logic                                cfg_we
);
  import dav_pkg::*;

  logic [VOL_W-1:0] last_vol_r;
  logic             have_r;
  logic             out_fire;

  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_fire) begin
      have_r     <= 1'b1;
      last_vol_r <= out_envelope_volume;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pwm_level)
      && $stable(out_envelope_volume) && $stable(out_note_active))
    else $error("stalled result transaction changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("result or intake active right after reset");

  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken right after cfg write");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_note_active |-> out_envelope_volume == '0)
    else $error("idle envelope with nonzero volume");

  a_vol_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && have_r |-> out_envelope_volume == last_vol_r
      || out_envelope_volume == last_vol_r + VOL_W'(1)
      || out_envelope_volume + VOL_W'(1) == last_vol_r)
    else $error("volume jumped by more than one step");

endmodule

bind dds_adsr_voice_core dav_checker u_dav_checker (.*);

// File: sim/dds_adsr_voice_core_checker.sv
// checker for dds_adsr_voice_core: mirrors the voice state and compares every tick result
module dds_adsr_voice_core_checker
  import dav_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [TUNE_W-1:0]          in_tuning_word,
  input  logic [TIDX_W-1:0]          in_table_index,
  input  logic signed [SAMPLE_W-1:0] in_table_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [PWM_W-1:0]           out_pwm_level,
  input  logic [VOL_W-1:0]           out_envelope_volume,
  input  logic                       out_note_active,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         fail_count,
  output int                         pending_count
);

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic [VOL_W-1:0] vol;
    logic             active;
  } voice_sample_t;

  voice_sample_t tick_results[$];
  int            results_seen;

  logic [AR_W-1:0]  atk_rate;
  logic [DR_W-1:0]  dcy_rate;
  logic [VOL_W-1:0] sus_lvl;
  logic [ST_W-1:0]  sus_ticks;
  logic [RR_W-1:0]  rel_rate;

  logic [DEF_PHASE_BITS-1:0] phase_acc;
  logic [DEF_PHASE_BITS-1:0] phase_step;
  logic [VOL_W-1:0]          volume;
  logic [CNT_W-1:0]          env_count;
  logic signed [SAMPLE_W-1:0] wave_ram [DEF_TABLE_DEPTH];

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("mismatch on %s, result %0d at %0t: expected %0d got %0d",
             what, results_seen, $time, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : voice_model
    voice_sample_t want;
    logic signed [SAMPLE_W-1:0] sample;
    int     prod;
    int     scaled;
    longint full, atk, dcy, lvl, hold, rel, vol, cnt;
    longint a_end, d_end, r_start;
    if (!rst_n) begin
      atk_rate     = ATTACK_RST;
      dcy_rate     = DECAY_RST;
      sus_lvl      = SUSTAIN_LVL_RST;
      sus_ticks    = SUSTAIN_TIME_RST;
      rel_rate     = RELEASE_RST;
      phase_acc    = '0;
      phase_step   = '0;
      volume       = '0;
      env_count    = '0;
      fail_count   = 0;
      results_seen = 0;
      tick_results.delete();
    end else begin
      // results first: a result always belongs to an earlier transaction
      if (out_valid && !out_stall) begin
        results_seen++;
        if (tick_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_pwm_level);
        end else begin
          want = tick_results.pop_front();
          if (out_pwm_level !== want.pwm)
            report_mismatch("pwm_level", want.pwm, out_pwm_level);
          if (out_envelope_volume !== want.vol)
            report_mismatch("envelope_volume", want.vol, out_envelope_volume);
          if (out_note_active !== want.active)
            report_mismatch("note_active", want.active, out_note_active);
        end
      end

      if (in_valid && !in_stall) begin
        case (mode_t'(in_mode))
          MODE_TICK: begin
            phase_acc = phase_acc + phase_step;
            sample    = wave_ram[phase_acc[DEF_PHASE_BITS-1 -: TIDX_W]];
            prod      = int'(sample) * int'(volume);
            scaled    = (prod + (PWM_MID << VOL_SHIFT)) >>> VOL_SHIFT;
            want.pwm  = scaled[PWM_W-1:0];

            // envelope step
            if (env_count != '0) begin
              if (env_count != COUNTER_MAX)
                env_count = env_count + 1'b1;
              full    = FULL_VOL;
              atk     = atk_rate;
              dcy     = dcy_rate;
              lvl     = sus_lvl;
              hold    = sus_ticks;
              rel     = rel_rate;
              vol     = volume;
              cnt     = env_count;
              a_end   = atk * full;
              d_end   = a_end + (full - lvl) * dcy;
              r_start = d_end + hold;
              if (cnt < a_end) begin
                if (cnt > atk * vol && vol < full)
                  volume = volume + 1'b1;
              end else if (cnt < d_end) begin
                if (cnt - a_end > (full - vol) * dcy && vol > lvl)
                  volume = volume - 1'b1;
              end else if (cnt > r_start) begin
                if (cnt - r_start > (lvl - vol) * rel) begin
                  if (vol > 0)
                    volume = volume - 1'b1;
                  else
                    env_count = '0;
                end
              end
            end
            want.vol    = volume;
            want.active = (env_count != '0);
            tick_results.push_back(want);
          end
          MODE_NOTE: begin
            if (env_count == '0) begin
              phase_step = in_tuning_word;
              env_count  = 1;
            end
          end
          MODE_WRITE: wave_ram[in_table_index] = in_table_value;
          default: ;
        endcase
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ATTACK:   atk_rate  = cfg_data[AR_W-1:0];
          REG_DECAY:    dcy_rate  = cfg_data[DR_W-1:0];
          REG_SUS_LVL:  sus_lvl   = cfg_data[VOL_W-1:0];
          REG_SUS_TIME: sus_ticks = cfg_data[ST_W-1:0];
          REG_RELEASE:  rel_rate  = cfg_data[RR_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count = tick_results.size();
  end

endmodule

// File: sim/dds_adsr_voice_core_test.sv
// testbench top for dds_adsr_voice_core: clock, reset, stimulus, watchdog and verdict
module dds_adsr_voice_core_test;
  import dav_pkg::*;

  localparam int QUIET_LIMIT     = 1000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 88;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [MODE_W-1:0]          in_mode;
  logic [TUNE_W-1:0]          in_tuning_word;
  logic [TIDX_W-1:0]          in_table_index;
  logic signed [SAMPLE_W-1:0] in_table_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [PWM_W-1:0]           out_pwm_level;
  logic [VOL_W-1:0]           out_envelope_volume;
  logic                       out_note_active;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int fail_count;
  int pending_count;
  int in_idle_pct;
  int out_idle_pct;
  int quiet_cycles = 0;

  dds_adsr_voice_core uut (.*);

  dds_adsr_voice_core_checker voice_check (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int draw_wait(int pct);
    if (int'($urandom_range(99, 0)) < pct)
      return int'($urandom_range(14, 0));
    return 0;
  endfunction

  function automatic int draw_pct();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 30;
      default: return 100;
    endcase
  endfunction

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("dds_adsr_voice_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = draw_wait(out_idle_pct);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(mode_t mode, logic [TUNE_W-1:0] tune,
                           logic [TIDX_W-1:0] idx, logic signed [SAMPLE_W-1:0] val);
    int gap;
    gap = draw_wait(in_idle_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_tuning_word <= tune;
    in_table_index <= idx;
    in_table_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // only with the block drained: no results owed, notes and writes settled
  task automatic write_regs(logic [AR_W-1:0] atk, logic [DR_W-1:0] dcy,
                            logic [VOL_W-1:0] lvl, logic [ST_W-1:0] hold,
                            logic [RR_W-1:0] rel);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    put_reg(REG_ATTACK, CFG_DATA_W'(atk));
    put_reg(REG_DECAY, CFG_DATA_W'(dcy));
    put_reg(REG_SUS_LVL, CFG_DATA_W'(lvl));
    put_reg(REG_SUS_TIME, CFG_DATA_W'(hold));
    put_reg(REG_RELEASE, CFG_DATA_W'(rel));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int               counted;
    int               pick;
    mode_t            mode;
    logic [AR_W-1:0]  atk;
    logic [DR_W-1:0]  dcy;
    logic [VOL_W-1:0] lvl;
    logic [ST_W-1:0]  hold;
    logic [RR_W-1:0]  rel;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_TICK;
    in_tuning_word = '0;
    in_table_index = '0;
    in_table_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_ATTACK;
    cfg_data       = '0;
    in_idle_pct    = 30;
    out_idle_pct   = 30;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill the whole wave table so no tick reads an unwritten entry
    for (int i = 0; i < DEF_TABLE_DEPTH; i++)
      send_item(MODE_WRITE, TUNE_W'($urandom), i[TIDX_W-1:0], SAMPLE_W'($urandom));

    // directed: idle tick, unused mode, table extremes, note extremes, busy note
    send_item(MODE_TICK, '0, '0, '0);
    send_item(MODE_NONE, '1, '1, '1);
    send_item(MODE_WRITE, '0, 8'hFF, 8'sd127);
    send_item(MODE_WRITE, '1, 8'h00, -8'sd128);
    send_item(MODE_TICK, '1, '1, '1);
    send_item(MODE_NOTE, 16'hFFFF, '0, '0);
    send_item(MODE_NOTE, 16'h0000, '1, '1);
    for (int i = 0; i < 12; i++)
      send_item(MODE_TICK, TUNE_W'($urandom), TIDX_W'($urandom), SAMPLE_W'($urandom));
    send_item(MODE_NONE, '0, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        atk = '0; dcy = '0; lvl = '0; hold = '0; rel = '0;
      end else if (p == 1) begin
        atk = '1; dcy = '1; lvl = '1; hold = '1; rel = '1;
      end else begin
        atk  = AR_W'($urandom_range(3, 0));
        dcy  = DR_W'($urandom_range(3, 0));
        lvl  = VOL_W'($urandom);
        hold = ST_W'($urandom_range(40, 0));
        rel  = RR_W'($urandom_range(4, 0));
        case ($urandom_range(7, 0))
          0: atk  = AR_W'($urandom);
          1: dcy  = DR_W'($urandom);
          2: hold = ST_W'($urandom);
          3: rel  = RR_W'($urandom);
          default: ;
        endcase
      end
      write_regs(atk, dcy, lvl, hold, rel);
      in_idle_pct  = draw_pct();
      out_idle_pct = draw_pct();

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = int'($urandom_range(99, 0));
        if (pick < 78)
          mode = MODE_TICK;
        else if (pick < 88)
          mode = MODE_NOTE;
        else if (pick < 97)
          mode = MODE_WRITE;
        else
          mode = MODE_NONE;
        counted++;
        send_item(mode, TUNE_W'($urandom), TIDX_W'($urandom), SAMPLE_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("dds_adsr_voice_core verification clean");
    else
      $display("dds_adsr_voice_core verification failed");
    $finish;
  end

endmodule

// File: files.f
design/dav_pkg.sv
design/dds_adsr_voice_core.sv
design/dav_checker.sv
sim/dds_adsr_voice_core_checker.sv
sim/dds_adsr_voice_core_test.sv
